// File: hdl/tmvp_pkg.sv
// Shared types and constants for the ternary weight matrix-vector product.
package tmvp_pkg;

  // Fixed field widths
  localparam int CNT_W    = 7;
  localparam int ACC_W    = 23;
  localparam int SAMPLE_W = 16;
  localparam int SCALE_W  = 16;
  localparam int VALUE_W  = 30;
  localparam int PROD_W   = ACC_W + SCALE_W;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 6;
  localparam int FRAC_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED    = 2'd2;

  // Reset values of the configuration registers
  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd256;
  localparam logic [CNT_W-1:0]   ROWS_RST  = 7'd64;
  localparam logic [CNT_W-1:0]   COLS_RST  = 7'd64;

  // Input operations
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Ternary weight encodings; anything else reads as zero
  localparam logic [1:0] TRIT_POS = 2'b01;
  localparam logic [1:0] TRIT_NEG = 2'b11;

  // Per-beat control broadcast to every cell
  typedef struct packed {
    logic                       acc_en;
    logic                       close;
    logic                       shift_en;
    logic signed [SAMPLE_W-1:0] sample;
  } cell_ctl_t;

  // One result headed into the scaling stage
  typedef struct packed {
    logic                    err;
    logic                    last;
    logic [ROW_W-1:0]        idx;
    logic signed [ACC_W-1:0] sum;
  } res_t;

endpackage

// File: hdl/tmvp_cell.sv
// One matrix row: weight memory, accumulator and a drain shift stage.
module tmvp_cell #(
  parameter int MAX_COLS = 64,
  parameter int ADDR_W   = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [ADDR_W-1:0]                   wr_col,
  input  logic [1:0]                          wr_val,
  input  logic [ADDR_W-1:0]                   rd_addr,
  input  tmvp_pkg::cell_ctl_t                 ctl,
  input  logic signed [tmvp_pkg::ACC_W-1:0]   shift_in,
  output logic signed [tmvp_pkg::ACC_W-1:0]   shift_out
);
  import tmvp_pkg::*;

  logic [1:0]              mem [MAX_COLS];
  logic [1:0]              wt_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] hold_r;

  // Weight memory; read is prefetched for the next column, writes forward
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_col] <= wr_val;
    end
    if (wr_en && (wr_col == rd_addr)) begin
      wt_r <= wr_val;
    end else begin
      wt_r <= mem[rd_addr];
    end
  end

  // Add, subtract or skip the sample
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.acc_en) begin
      if (wt_r == TRIT_POS) begin
        acc_nxt = acc_r + ACC_W'(ctl.sample);
      end else if (wt_r == TRIT_NEG) begin
        acc_nxt = acc_r - ACC_W'(ctl.sample);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.close) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // Drain stage: loaded with the final sum, then shifted toward row 0
  always_ff @(posedge clk) begin
    if (ctl.close) begin
      hold_r <= acc_nxt;
    end else if (ctl.shift_en) begin
      hold_r <= shift_in;
    end
  end

  assign shift_out = hold_r;

endmodule

// File: hdl/tmvp_out.sv
// Scaling multiplier and output register with stall handling.
module tmvp_out (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic signed [tmvp_pkg::SCALE_W-1:0]   scale,
  input  logic                                  issue_v,
  input  tmvp_pkg::res_t                        issue,
  output logic                                  take,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [tmvp_pkg::ROW_W-1:0]            out_row_index,
  output logic signed [tmvp_pkg::VALUE_W-1:0]   out_value,
  output logic                                  out_status,
  output logic                                  out_last_res
);
  import tmvp_pkg::*;

  logic                     p_v_r;
  logic                     p_err_r;
  logic                     p_last_r;
  logic [ROW_W-1:0]         p_idx_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic                     out_valid_r;

  assign take     = !out_valid_r || out_ready;
  assign prod_nxt = PROD_W'(issue.sum) * PROD_W'(scale);

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (take) begin
      p_v_r       <= issue_v;
      out_valid_r <= p_v_r;
    end
  end

  // Product stage and output register; the >>8 floors by bit selection
  always_ff @(posedge clk) begin
    if (take) begin
      p_err_r       <= issue.err;
      p_last_r      <= issue.last;
      p_idx_r       <= issue.idx;
      prod_r        <= prod_nxt;
      out_row_index <= p_idx_r;
      out_value     <= p_err_r ? '0 : prod_r[FRAC_W+VALUE_W-1:FRAC_W];
      out_status    <= p_err_r;
      out_last_res  <= p_last_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hdl/ternary_weight_matrix_vector_product.sv
// Top level: control, configuration and the chain of row cells.
// Throughput: one weight load or one sample per cycle while in_ready is high;
// a sample updates all row accumulators in the cycle it is accepted.
// A closing sample hands the sums to the drain chain; results leave one per
// cycle from row 0 while out_ready allows, each passing the product and
// output registers; input is held off until every reported row (or the one
// error result for a length error) has left the chain for the scaling multiplier.
// Reset (synchronous, rst_n low) clears accumulators, count, control and
// loads config defaults; weight memories keep contents and are not cleared.
module ternary_weight_matrix_vector_product #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [tmvp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tmvp_pkg::SCALE_W-1:0]          cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_op,
  input  logic [tmvp_pkg::ROW_W-1:0]            in_weight_row,
  input  logic [tmvp_pkg::COL_W-1:0]            in_weight_col,
  input  logic signed [1:0]                     in_weight_value,
  input  logic signed [tmvp_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [tmvp_pkg::ROW_W-1:0]            out_row_index,
  output logic signed [tmvp_pkg::VALUE_W-1:0]   out_value,
  output logic                                  out_status,
  output logic                                  out_last_res
);
  import tmvp_pkg::*;

  localparam int ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_ERR   = 2'd2;

  logic [1:0]               state_r;
  logic [1:0]               state_nxt;
  logic signed [SCALE_W-1:0] scale_r;
  logic [CNT_W-1:0]         rows_used_r;
  logic [CNT_W-1:0]         cols_used_r;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic [CNT_W-1:0]         count_inc;
  logic [CNT_W-1:0]         idx_r;
  logic [CNT_W-1:0]         idx_nxt;
  logic [CNT_W-1:0]         rows_eff;
  logic                     beat;
  logic                     load_beat;
  logic                     smp_beat;
  logic                     close_ok;
  logic                     close_err;
  logic                     wr_ok;
  logic                     take;
  logic                     issue_v;
  logic                     drain_last;
  res_t                     issue;
  cell_ctl_t                ctl;
  logic [CNT_W+ADDR_W-1:0]  rd_ext;
  logic [COL_W+ADDR_W-1:0]  col_ext;
  logic [ADDR_W-1:0]        rd_addr;
  logic [ADDR_W-1:0]        wr_col;
  logic signed [ACC_W-1:0]  chain [MAX_ROWS+1];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= SCALE_RST;
      rows_used_r <= ROWS_RST;
      cols_used_r <= COLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WEIGHT_SCALE: scale_r     <= cfg_wdata;
        CFG_ROWS_USED:    rows_used_r <= cfg_wdata[CNT_W-1:0];
        CFG_COLS_USED:    cols_used_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake
  assign in_ready  = (state_r == ST_IDLE);
  assign beat      = in_valid && in_ready;
  assign load_beat = beat && (in_op == OP_LOAD);
  assign smp_beat  = beat && (in_op == OP_SAMPLE);

  // Sample counter, saturating
  assign count_inc = (count_r < COUNT_MAX) ? count_r + 1'b1 : count_r;
  assign close_ok  = smp_beat && in_last && (count_inc == cols_used_r);
  assign close_err = smp_beat && in_last && (count_inc != cols_used_r);

  always_comb begin
    count_nxt = count_r;
    if (smp_beat) begin
      count_nxt = in_last ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Weight addressing; read address tracks the next column
  assign rd_ext  = (CNT_W+ADDR_W)'(count_nxt);
  assign rd_addr = rd_ext[ADDR_W-1:0];
  assign col_ext = (COL_W+ADDR_W)'(in_weight_col);
  assign wr_col  = col_ext[ADDR_W-1:0];
  assign wr_ok   = load_beat && (32'(in_weight_col) < MAX_COLS);

  // Rows reported, clamped to 1..MAX_ROWS
  always_comb begin
    if (rows_used_r == '0) begin
      rows_eff = CNT_W'(1);
    end else if (32'(rows_used_r) > MAX_ROWS) begin
      rows_eff = CNT_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_used_r;
    end
  end

  // Broadcast control
  assign drain_last   = (32'(idx_r) + 1 == 32'(rows_eff));
  assign ctl.acc_en   = smp_beat && (32'(count_r) < MAX_COLS) && (count_r < cols_used_r);
  assign ctl.close    = smp_beat && in_last;
  assign ctl.shift_en = (state_r == ST_DRAIN) && take;
  assign ctl.sample   = in_sample;

  // Drain sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (close_ok) begin
          state_nxt = ST_DRAIN;
        end else if (close_err) begin
          state_nxt = ST_ERR;
        end
      end
      ST_DRAIN: begin
        if (take) begin
          idx_nxt = idx_r + 1'b1;
          if (drain_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Result headed for the scaling stage
  assign issue_v    = (state_r == ST_DRAIN) || (state_r == ST_ERR);
  assign issue.err  = (state_r == ST_ERR);
  assign issue.last = (state_r == ST_ERR) || drain_last;
  assign issue.idx  = (state_r == ST_ERR) ? '0 : idx_r[ROW_W-1:0];
  assign issue.sum  = chain[0];

  // Row cells; drain chain shifts toward row 0, zero enters at the far end
  assign chain[MAX_ROWS] = '0;

  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_row
    logic wr_en;
    assign wr_en = wr_ok && (32'(in_weight_row) == i);

    tmvp_cell #(
      .MAX_COLS (MAX_COLS),
      .ADDR_W   (ADDR_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (wr_en),
      .wr_col    (wr_col),
      .wr_val    (in_weight_value),
      .rd_addr   (rd_addr),
      .ctl       (ctl),
      .shift_in  (chain[i+1]),
      .shift_out (chain[i])
    );
  end

  tmvp_out u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .scale         (scale_r),
    .issue_v       (issue_v),
    .issue         (issue),
    .take          (take),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row_index (out_row_index),
    .out_value     (out_value),
    .out_status    (out_status),
    .out_last_res  (out_last_res)
  );

endmodule
